>>> hdl/msf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_pkg: shared types and constants of the multimode smoothing filter
// Widths, fixed-point constants, config register map, microcode word layout
// and program addresses.
// ----------------------------------------------------------------------------
package msf_pkg;

    // Data format: signed Q16.16 samples and results
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;

    // Config register widths
    localparam int MODE_W     = 2;
    localparam int RATE_W     = 16;
    localparam int S_W        = 17;
    localparam int PERIOD_W   = 25;
    localparam int PERIOD_FRAC = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 25;

    // Datapath widths
    localparam int D_W    = DATA_W + 1;     // exact difference of two samples
    localparam int REM_W  = DATA_W + 2;     // magnitude during the angle wrap
    localparam int MB_W   = PERIOD_W + 1;   // second multiplier operand, signed
    localparam int PROD_W = D_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int K_W    = 4;

    // Integrate mode: s*prev is at 2^32, sample*period at 2^40
    localparam int INT_SHIFT = PERIOD_FRAC;
    localparam int INT_ALIGN = PERIOD_FRAC - FRAC_BITS;

    localparam logic [S_W-1:0] SMOOTH_ONE = S_W'(65536);

    // pi and two pi in Q16.16
    localparam logic [REM_W-1:0] PI_FIX     = REM_W'(205887);
    localparam logic [REM_W-1:0] TWO_PI_FIX = REM_W'(411775);
    localparam logic [K_W-1:0]   K_MAX      = {K_W{1'b1}};

    // Config register map
    localparam logic [CFG_IDX_W-1:0] REG_MODE          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HZ       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = CFG_IDX_W'(3);

    localparam logic [RATE_W-1:0]   RATE_HZ_RST       = RATE_W'(1000);
    localparam logic [S_W-1:0]      SMOOTHING_RST     = S_W'(58982);
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = PERIOD_W'(16777);

    typedef enum logic [MODE_W-1:0] {
        MODE_SMOOTH    = 2'd0,
        MODE_RATE      = 2'd1,
        MODE_ANGLE     = 2'd2,
        MODE_INTEGRATE = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [RATE_W-1:0]   rate_hz;
        logic [S_W-1:0]      smoothing;
        logic [PERIOD_W-1:0] sample_period;
    } cfg_t;

    // Microcode fields
    typedef enum logic [1:0] {
        MA_X, MA_PREV, MA_VEL, MA_D
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_ONE_MINUS_S, MB_S, MB_RATE, MB_PERIOD
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_RND_BLEND, ACC_RND_INT, ACC_ADD, ACC_ADD_ALIGN
    } acc_op_t;

    typedef enum logic [2:0] {
        D_HOLD, D_DIFF, D_WRAP_START, D_REM_STEP, D_WRAP_END, D_SAT_PROD
    } d_op_t;

    typedef enum logic [2:0] {
        WB_NONE, WB_PREV_X, WB_PREV_BLEND, WB_VEL_BLEND, WB_PREV_INT
    } wb_t;

    typedef enum logic [2:0] {
        J_NEXT, J_DISPATCH, J_IF_NOT_ANGLE, J_LOOP_K, J_DONE
    } jmp_t;

    localparam int PC_W       = 5;
    localparam int STEP_COUNT = 19;

    typedef struct packed {
        mul_a_t          mul_a;
        mul_b_t          mul_b;
        acc_op_t         acc_op;
        d_op_t           d_op;
        wb_t             wb;
        jmp_t            jmp;
        logic            k_load;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Program entry points
    localparam logic [PC_W-1:0] STEP_DISPATCH  = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_SMOOTH    = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_RATE      = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_WRAP      = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_REM       = PC_W'(7);
    localparam logic [PC_W-1:0] STEP_WRAP_END  = PC_W'(8);
    localparam logic [PC_W-1:0] STEP_SCALE     = PC_W'(9);
    localparam logic [PC_W-1:0] STEP_SAT_T     = PC_W'(10);
    localparam logic [PC_W-1:0] STEP_VBLEND0   = PC_W'(11);
    localparam logic [PC_W-1:0] STEP_VBLEND1   = PC_W'(12);
    localparam logic [PC_W-1:0] STEP_VBLEND2   = PC_W'(13);
    localparam logic [PC_W-1:0] STEP_VDONE     = PC_W'(14);
    localparam logic [PC_W-1:0] STEP_INTEGRATE = PC_W'(15);
    localparam logic [PC_W-1:0] STEP_INT1      = PC_W'(16);
    localparam logic [PC_W-1:0] STEP_INT2      = PC_W'(17);
    localparam logic [PC_W-1:0] STEP_INT_DONE  = PC_W'(18);

    localparam logic [PC_W-1:0] STEP_SM1     = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_SM2     = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_SM_DONE = PC_W'(4);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

endpackage : msf_pkg
`default_nettype wire

>>> hdl/msf_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_cfg_regs: configuration registers
// Takes register writes by index and holds mode, rate, smoothing and period.
// ----------------------------------------------------------------------------
module msf_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [msf_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [msf_pkg::CFG_DATA_W-1:0] wr_data,
    output msf_pkg::cfg_t                    cfg
);
    import msf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_SMOOTH;
            cfg_reg.rate_hz       <= RATE_HZ_RST;
            cfg_reg.smoothing     <= SMOOTHING_RST;
            cfg_reg.sample_period <= SAMPLE_PERIOD_RST;
        end
        else if (wr_en)
        begin
            // drop writes to unknown indexes
            case (wr_index)
                REG_MODE:          cfg_reg.mode          <= mode_t'(wr_data[MODE_W-1:0]);
                REG_RATE_HZ:       cfg_reg.rate_hz       <= wr_data[RATE_W-1:0];
                REG_SMOOTHING:     cfg_reg.smoothing     <= wr_data[S_W-1:0];
                REG_SAMPLE_PERIOD: cfg_reg.sample_period <= wr_data[PERIOD_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : msf_cfg_regs
`default_nettype wire

>>> hdl/msf_ucode_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_ucode_rom: control store
// One control word per program step for the four filter modes.
// ----------------------------------------------------------------------------
module msf_ucode_rom (
    input  wire logic [msf_pkg::PC_W-1:0] pc,
    output msf_pkg::ctrl_word_t           ctrl
);
    import msf_pkg::*;

    always_comb
    begin
        case (pc)
            STEP_DISPATCH:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_HOLD, WB_NONE, J_DISPATCH, 1'b0, STEP_SMOOTH};

            // smooth: prev = blend(x, prev)
            STEP_SMOOTH:
                ctrl = '{MA_X, MB_ONE_MINUS_S, ACC_RND_BLEND, D_HOLD, WB_NONE, J_NEXT,
                         1'b0, STEP_DISPATCH};
            STEP_SM1:
                ctrl = '{MA_PREV, MB_S, ACC_ADD, D_HOLD, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_SM2:
                ctrl = '{MA_PREV, MB_S, ACC_ADD, D_HOLD, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_SM_DONE:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_HOLD, WB_PREV_BLEND, J_DONE, 1'b0,
                         STEP_DISPATCH};

            // rate and angle rate
            STEP_RATE:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_DIFF, WB_NONE, J_IF_NOT_ANGLE, 1'b0, STEP_SCALE};
            STEP_WRAP:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_WRAP_START, WB_NONE, J_NEXT, 1'b1,
                         STEP_DISPATCH};
            STEP_REM:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_REM_STEP, WB_NONE, J_LOOP_K, 1'b0, STEP_REM};
            STEP_WRAP_END:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_WRAP_END, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_SCALE:
                ctrl = '{MA_D, MB_RATE, ACC_HOLD, D_HOLD, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_SAT_T:
                ctrl = '{MA_D, MB_RATE, ACC_RND_BLEND, D_SAT_PROD, WB_PREV_X, J_NEXT, 1'b0,
                         STEP_DISPATCH};
            STEP_VBLEND0:
                ctrl = '{MA_D, MB_ONE_MINUS_S, ACC_HOLD, D_HOLD, WB_NONE, J_NEXT, 1'b0,
                         STEP_DISPATCH};
            STEP_VBLEND1:
                ctrl = '{MA_VEL, MB_S, ACC_ADD, D_HOLD, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_VBLEND2:
                ctrl = '{MA_VEL, MB_S, ACC_ADD, D_HOLD, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_VDONE:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_HOLD, WB_VEL_BLEND, J_DONE, 1'b0, STEP_DISPATCH};

            // leaky integrate: prev = s*prev + x*period
            STEP_INTEGRATE:
                ctrl = '{MA_PREV, MB_S, ACC_RND_INT, D_HOLD, WB_NONE, J_NEXT, 1'b0,
                         STEP_DISPATCH};
            STEP_INT1:
                ctrl = '{MA_X, MB_PERIOD, ACC_ADD_ALIGN, D_HOLD, WB_NONE, J_NEXT, 1'b0,
                         STEP_DISPATCH};
            STEP_INT2:
                ctrl = '{MA_X, MB_PERIOD, ACC_ADD, D_HOLD, WB_NONE, J_NEXT, 1'b0, STEP_DISPATCH};
            STEP_INT_DONE:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_HOLD, WB_PREV_INT, J_DONE, 1'b0, STEP_DISPATCH};

            default:
                ctrl = '{MA_X, MB_S, ACC_HOLD, D_HOLD, WB_NONE, J_DONE, 1'b0, STEP_DISPATCH};
        endcase
    end

endmodule : msf_ucode_rom
`default_nettype wire

>>> hdl/msf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_datapath: filter datapath
// One registered multiplier, an accumulator, a difference/wrap register and
// the filter state, all steered by the current control word.
// ----------------------------------------------------------------------------
module msf_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load_x,
    input  wire logic signed [msf_pkg::DATA_W-1:0] sample,
    input  wire logic                              step_en,
    input  wire msf_pkg::ctrl_word_t               ctrl,
    input  wire logic [msf_pkg::K_W-1:0]           k,
    input  wire msf_pkg::cfg_t                     cfg,
    output logic signed [msf_pkg::DATA_W-1:0]      result
);
    import msf_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_BLEND = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_INT   = ACC_W'(1) <<< (INT_SHIFT - 1);

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic signed [DATA_W-1:0] vel_reg, vel_next;
    logic signed [D_W-1:0]    d_reg, d_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic                     pos_reg, pos_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic [S_W-1:0]           s_eff;
    logic [S_W-1:0]           one_minus_s;
    logic signed [D_W-1:0]    mul_a;
    logic [MB_W-1:0]          mul_b_u;
    logic signed [MB_W-1:0]   mul_b;
    logic                     d_pos;
    logic signed [REM_W:0]    d_wide;
    logic signed [REM_W:0]    wrap_v;
    logic signed [REM_W:0]    wrap_out;
    logic [REM_W-1:0]         rem_sub;
    logic signed [ACC_W-1:0]  prod_ext;

    assign s_eff       = (cfg.smoothing > SMOOTH_ONE) ? SMOOTH_ONE : cfg.smoothing;
    assign one_minus_s = SMOOTH_ONE - s_eff;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (ctrl.mul_a)
            MA_X:    mul_a = D_W'(x_reg);
            MA_PREV: mul_a = D_W'(prev_reg);
            MA_VEL:  mul_a = D_W'(vel_reg);
            MA_D:    mul_a = d_reg;
            default: mul_a = d_reg;
        endcase
        case (ctrl.mul_b)
            MB_ONE_MINUS_S: mul_b_u = MB_W'(one_minus_s);
            MB_S:           mul_b_u = MB_W'(s_eff);
            MB_RATE:        mul_b_u = MB_W'(cfg.rate_hz);
            MB_PERIOD:      mul_b_u = MB_W'(cfg.sample_period);
            default:        mul_b_u = MB_W'(s_eff);
        endcase
    end

    assign mul_b     = $signed(mul_b_u);
    assign prod_next = mul_a * mul_b;
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_RND_BLEND: acc_next = RND_BLEND;
            ACC_RND_INT:   acc_next = RND_INT;
            ACC_ADD:       acc_next = acc_reg + prod_ext;
            ACC_ADD_ALIGN: acc_next = acc_reg + (prod_ext <<< INT_ALIGN);
            default:       acc_next = acc_reg;
        endcase
    end

    // angle wrap: remainder by two pi, one shifted compare and subtract per step
    assign d_pos    = (d_reg > 0);
    assign d_wide   = (REM_W+1)'(d_reg);
    assign wrap_v   = d_pos ? d_wide + $signed({1'b0, PI_FIX})
                            : d_wide - $signed({1'b0, PI_FIX});
    assign rem_sub  = TWO_PI_FIX << k;
    assign wrap_out = pos_reg ? $signed({1'b0, rem_reg}) - $signed({1'b0, PI_FIX})
                              : $signed({1'b0, PI_FIX}) - $signed({1'b0, rem_reg});

    always_comb
    begin
        d_next   = d_reg;
        rem_next = rem_reg;
        pos_next = pos_reg;
        case (ctrl.d_op)
            D_DIFF:
                d_next = D_W'(x_reg) - D_W'(prev_reg);
            D_WRAP_START:
            begin
                pos_next = d_pos;
                rem_next = wrap_v[REM_W] ? REM_W'(-wrap_v) : wrap_v[REM_W-1:0];
            end
            D_REM_STEP:
            begin
                if (rem_reg >= rem_sub)
                    rem_next = rem_reg - rem_sub;
            end
            D_WRAP_END:
                d_next = wrap_out[D_W-1:0];
            D_SAT_PROD:
                d_next = D_W'(sat_data(prod_ext));
            default:
                d_next = d_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.wb)
            WB_PREV_INT: result = sat_data(acc_reg >>> INT_SHIFT);
            default:     result = sat_data(acc_reg >>> FRAC_BITS);
        endcase
    end

    always_comb
    begin
        prev_next = prev_reg;
        vel_next  = vel_reg;
        case (ctrl.wb)
            WB_PREV_X:     prev_next = x_reg;
            WB_PREV_BLEND: prev_next = result;
            WB_PREV_INT:   prev_next = result;
            WB_VEL_BLEND:  vel_next  = result;
            default:       prev_next = prev_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            vel_reg  <= '0;
        end
        else if (step_en)
        begin
            prev_reg <= prev_next;
            vel_reg  <= vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_x)
            x_reg <= sample;
        if (step_en)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            d_reg    <= d_next;
            rem_reg  <= rem_next;
            pos_reg  <= pos_next;
        end
    end

endmodule : msf_datapath
`default_nettype wire

>>> hdl/multimode_smoothing_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multimode_smoothing_filter: exponential moving average filter, four modes
// Microcoded smoothing, rate, angle-rate and leaky-integrate filter on signed
// Q16.16 samples.
// ----------------------------------------------------------------------------
// One sample in, one saturated Q16.16 result out. A sample is taken only while
// the sequencer is idle; the result then sits in an output register, so the
// next sample can be taken while it waits. The run time of an item depends on
// the mode and is set by the single shared multiplier, whose products are
// registered before they are accumulated, and in angle-rate mode by the
// 16-step remainder loop that wraps the difference into -pi..pi.
// Config writes are always accepted and must only be issued while idle.
// ----------------------------------------------------------------------------
module multimode_smoothing_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [msf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [msf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [msf_pkg::DATA_W-1:0] sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [msf_pkg::DATA_W-1:0]      filtered
);
    import msf_pkg::*;

    cfg_t                     cfg;
    ctrl_word_t               ctrl;
    seq_state_t               state_reg, state_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_reg;
    logic signed [DATA_W-1:0] result;
    logic                     in_xfer;
    logic                     stall;
    logic                     step_en;
    logic                     finish;

    assign cfg_ready = 1'b1;

    msf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    msf_ucode_rom u_rom (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    msf_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .load_x  (in_xfer),
        .sample  (sample),
        .step_en (step_en),
        .ctrl    (ctrl),
        .k       (k_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // hold the final step while the previous result is still waiting
    assign stall   = (ctrl.jmp == J_DONE) && out_valid_reg && !out_ready;
    assign step_en = (state_reg == ST_RUN) && !stall;
    assign finish  = step_en && (ctrl.jmp == J_DONE);

    always_comb
    begin
        pc_next    = pc_reg;
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_RUN;
                    pc_next    = STEP_DISPATCH;
                end
            end
            ST_RUN:
            begin
                if (step_en)
                begin
                    if (ctrl.k_load)
                        k_next = K_MAX;
                    case (ctrl.jmp)
                        J_DISPATCH:
                        begin
                            case (cfg.mode)
                                MODE_SMOOTH:    pc_next = STEP_SMOOTH;
                                MODE_RATE:      pc_next = STEP_RATE;
                                MODE_ANGLE:     pc_next = STEP_RATE;
                                MODE_INTEGRATE: pc_next = STEP_INTEGRATE;
                                default:        pc_next = STEP_SMOOTH;
                            endcase
                        end
                        J_IF_NOT_ANGLE:
                            pc_next = (cfg.mode != MODE_ANGLE) ? ctrl.target : pc_reg + 1'b1;
                        J_LOOP_K:
                        begin
                            if (k_reg != '0)
                            begin
                                k_next  = k_reg - 1'b1;
                                pc_next = ctrl.target;
                            end
                            else
                                pc_next = pc_reg + 1'b1;
                        end
                        J_DONE:
                        begin
                            state_next = ST_IDLE;
                            pc_next    = STEP_DISPATCH;
                        end
                        default:
                            pc_next = pc_reg + 1'b1;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pc_next    = STEP_DISPATCH;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= STEP_DISPATCH;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = out_reg;

`ifndef ASSERT_OFF
    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_RUN && pc_reg == STEP_DISPATCH)
        else $error("accepted sample did not start the program");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> pc_reg < PC_W'(STEP_COUNT))
        else $error("step counter left the program");

    a_finish_presents_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid && state_reg == ST_IDLE && filtered == $past(result))
        else $error("finished item not presented");

    a_loop_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && ctrl.jmp == J_LOOP_K && k_reg != '0 |=> k_reg == $past(k_reg) - 1'b1)
        else $error("remainder loop count did not advance");
`endif

endmodule : multimode_smoothing_filter
`default_nettype wire

>>> test/msf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_checker: result checker of the multimode smoothing filter
// Follows every config, sample and result transfer. It keeps its own copy of
// the mode registers and the filter state, and works out the filtered value
// for each accepted sample. Each result is compared with the oldest
// outstanding value.
// ----------------------------------------------------------------------------
module msf_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [msf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [msf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic signed [msf_pkg::DATA_W-1:0]   sample,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [msf_pkg::DATA_W-1:0]   filtered,
    output int                                       mismatches,
    output int                                       outstanding,
    output int                                       results_seen
);

    localparam longint Q_MAX      = 64'sd2147483647;
    localparam longint Q_MIN      = -64'sd2147483648;
    localparam longint ONE_Q16    = 64'sd65536;
    localparam longint PI_Q16     = 64'sd205887;   // pi rounded to Q16.16
    localparam longint TWO_PI_Q16 = 64'sd411775;
    localparam longint HALF_LSB24 = 64'sd8388608;

    msf_pkg::mode_t                   cur_mode;
    logic [msf_pkg::RATE_W-1:0]       cur_rate;
    logic [msf_pkg::S_W-1:0]          cur_smoothing;
    logic [msf_pkg::PERIOD_W-1:0]     cur_period;
    longint                           prev_value;
    longint                           vel;
    logic signed [msf_pkg::DATA_W-1:0] expected_filtered[$];
    logic signed [msf_pkg::DATA_W-1:0] want;

    function automatic longint clamp_q16(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // (1-s)*a + s*b, rounded to nearest, half-way case rounded up
    function automatic longint ema_blend(input longint a, input longint b, input longint s);
        longint acc;
        acc = (ONE_Q16 - s) * a + s * b + ONE_Q16 / 2;
        return clamp_q16(acc >>> 16);
    endfunction

    // % truncates toward zero, which the wrap relies on
    function automatic longint wrap_to_pi(input longint d);
        if (d > 0)
            return ((d + PI_Q16) % TWO_PI_Q16) - PI_Q16;
        return ((d - PI_Q16) % TWO_PI_Q16) + PI_Q16;
    endfunction

    function automatic logic signed [msf_pkg::DATA_W-1:0] filter_step(
        input logic signed [msf_pkg::DATA_W-1:0] x_in
    );
        longint x;
        longint s;
        longint d;
        longint acc;
        longint r;
        x = longint'(x_in);
        // weights above one act as one
        s = (cur_smoothing > 17'd65536) ? ONE_Q16 : longint'(cur_smoothing);
        case (cur_mode)
            msf_pkg::MODE_RATE, msf_pkg::MODE_ANGLE:
            begin
                d = x - prev_value;
                if (cur_mode == msf_pkg::MODE_ANGLE)
                    d = wrap_to_pi(d);
                vel = ema_blend(clamp_q16(d * longint'(cur_rate)), vel, s);
                prev_value = x;
                r = vel;
            end
            msf_pkg::MODE_INTEGRATE:
            begin
                // both terms at scale 2^40
                acc = s * prev_value * 256 + x * longint'(cur_period);
                prev_value = clamp_q16((acc + HALF_LSB24) >>> 24);
                r = prev_value;
            end
            default:
            begin
                prev_value = ema_blend(x, prev_value, s);
                r = prev_value;
            end
        endcase
        return r[msf_pkg::DATA_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode      = msf_pkg::MODE_SMOOTH;
            cur_rate      = 16'd1000;
            cur_smoothing = 17'd58982;
            cur_period    = 25'd16777;
            prev_value    = 0;
            vel           = 0;
            expected_filtered.delete();
            mismatches    = 0;
            results_seen  = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    msf_pkg::REG_MODE:
                        cur_mode = msf_pkg::mode_t'(cfg_data[msf_pkg::MODE_W-1:0]);
                    msf_pkg::REG_RATE_HZ:
                        cur_rate = cfg_data[msf_pkg::RATE_W-1:0];
                    msf_pkg::REG_SMOOTHING:
                        cur_smoothing = cfg_data[msf_pkg::S_W-1:0];
                    msf_pkg::REG_SAMPLE_PERIOD:
                        cur_period = cfg_data[msf_pkg::PERIOD_W-1:0];
                    default:
                        ;
                endcase
            end
            // retire before queueing: a result never belongs to this edge's sample
            if (out_valid && out_ready)
            begin
                if (expected_filtered.size() == 0)
                begin
                    $error("filtered: no result expected, actual 0x%08h (%0d)",
                           filtered, filtered);
                    mismatches++;
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (filtered !== want)
                    begin
                        $error("filtered: expected 0x%08h (%0d), actual 0x%08h (%0d)",
                               want, want, filtered, filtered);
                        mismatches++;
                    end
                    results_seen++;
                end
            end
            if (in_valid && in_ready)
                expected_filtered.push_back(filter_step(sample));
            outstanding = expected_filtered.size();
        end
    end

endmodule : msf_checker
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the multimode_smoothing_filter
// Drives directed samples at the mode and saturation corners, then random
// samples under random register settings, with phases of sender gaps,
// receiver stalls and long output backpressure. Checking is done by
// msf_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RUN_LIMIT    = 4000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 62;
    localparam int SETTLE       = 32;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [msf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [msf_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [msf_pkg::DATA_W-1:0]   sample = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [msf_pkg::DATA_W-1:0]   filtered;

    int mismatches;
    int outstanding;
    int results_seen;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_pending = 1'b0;
    int          samples_sent = 0;
    int          settings_used = 0;
    logic signed [msf_pkg::DATA_W-1:0] last_sample = '0;

    always #5 clk = ~clk;

    multimode_smoothing_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

    msf_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .filtered     (filtered),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // Receiver: random stalls, or a long hold-off counted here
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_pending = 1'b0;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_sample(input logic signed [msf_pkg::DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_sample = value;
        samples_sent++;
    endtask

    // Drop valid and hold until every outstanding result has been taken
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [msf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [msf_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Rewrite all four registers; junk_high fills the unused upper data bits
    task automatic configure(input msf_pkg::mode_t m,
                             input logic [msf_pkg::RATE_W-1:0] rate,
                             input logic [msf_pkg::S_W-1:0] s,
                             input logic [msf_pkg::PERIOD_W-1:0] period,
                             input bit junk_high,
                             input bit poke_unused);
        logic [msf_pkg::CFG_DATA_W-1:0] data;
        wait_for_results();
        data = junk_high ? msf_pkg::CFG_DATA_W'($urandom) : '0;
        data[msf_pkg::MODE_W-1:0] = m;
        write_reg(msf_pkg::REG_MODE, data);
        data = junk_high ? msf_pkg::CFG_DATA_W'($urandom) : '0;
        data[msf_pkg::RATE_W-1:0] = rate;
        write_reg(msf_pkg::REG_RATE_HZ, data);
        data = junk_high ? msf_pkg::CFG_DATA_W'($urandom) : '0;
        data[msf_pkg::S_W-1:0] = s;
        write_reg(msf_pkg::REG_SMOOTHING, data);
        write_reg(msf_pkg::REG_SAMPLE_PERIOD, period);
        if (poke_unused)
            write_reg(msf_pkg::CFG_IDX_W'($urandom_range(15, 4)), msf_pkg::CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    task automatic random_config();
        msf_pkg::mode_t             m;
        logic [msf_pkg::RATE_W-1:0] rate;
        logic [msf_pkg::S_W-1:0]    s;
        logic [msf_pkg::PERIOD_W-1:0] period;
        m = msf_pkg::mode_t'($urandom_range(3));
        case ($urandom_range(5))
            0:       rate = '0;
            1:       rate = 16'd1;
            2:       rate = 16'hFFFF;
            3:       rate = msf_pkg::RATE_W'($urandom_range(65535, 1));
            default: rate = msf_pkg::RATE_W'($urandom_range(5000, 1));
        endcase
        case ($urandom_range(5))
            0:       s = '0;
            1:       s = 17'd65536;
            2:       s = msf_pkg::S_W'($urandom_range(131071, 65537));
            3:       s = msf_pkg::S_W'($urandom_range(65535, 50000));
            default: s = msf_pkg::S_W'($urandom_range(65535));
        endcase
        case ($urandom_range(4))
            0:       period = '0;
            1:       period = 25'h1000000;
            2:       period = 25'h1FFFFFF;
            3:       period = msf_pkg::PERIOD_W'($urandom);
            default: period = msf_pkg::PERIOD_W'($urandom_range(32'h1000000));
        endcase
        configure(m, rate, s, period, 1'b1, ($urandom_range(3) == 0));
    endtask

    // Mix of raw words, extremes, small values and a wandering signal
    function automatic logic signed [msf_pkg::DATA_W-1:0] next_sample();
        int step;
        logic signed [msf_pkg::DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2:
                v = $urandom;
            3:
            begin
                case ($urandom_range(3))
                    0:       v = 32'sh7FFFFFFF;
                    1:       v = 32'sh80000000;
                    2:       v = '0;
                    default: v = -32'sd1;
                endcase
            end
            4, 5:
                v = int'($urandom_range(262143)) - 131072;
            default:
            begin
                step = int'($urandom_range(8191)) - 4096;
                // occasional jump of about two pi to cross the angle wrap
                if ($urandom_range(7) == 0)
                    step += ($urandom_range(1) != 0) ? 411775 : -411775;
                v = last_sample + step;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        #(RUN_LIMIT);
        $display("Run limit reached, %0d results still outstanding", outstanding);
        $display("[multimode_smoothing_filter] ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: smooth mode, default weight
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
        send_sample(32'sh00000000);
        send_sample(-32'sd1);
        send_sample(32'sd1);

        // Rate mode, largest rate: scaled difference saturates
        configure(msf_pkg::MODE_RATE, 16'hFFFF, 17'd0, 25'd0, 1'b0, 1'b0);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
        send_sample(32'sh00010000);

        // Zero rate, weight of one: velocity holds
        configure(msf_pkg::MODE_RATE, 16'd0, 17'd65536, 25'd0, 1'b0, 1'b0);
        send_sample(32'sd12345);
        send_sample(-32'sd99999);

        // Angle rate across and on the wrap boundaries; unknown index ignored
        configure(msf_pkg::MODE_ANGLE, 16'd1, 17'd0, 25'd0, 1'b0, 1'b1);
        send_sample(32'sd205887);
        send_sample(32'sd0);
        send_sample(-32'sd205887);
        send_sample(32'sd1235330);
        send_sample(32'sh80000000);
        send_sample(32'sh7FFFFFFF);

        // Integrate with weight over one and period over one: saturates
        configure(msf_pkg::MODE_INTEGRATE, 16'hFFFF, 17'h1FFFF, 25'h1FFFFFF, 1'b0, 1'b0);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
        send_sample(32'sh80000000);

        // Zero weight, unit period: output follows the sample
        configure(msf_pkg::MODE_INTEGRATE, 16'd1, 17'd0, 25'h1000000, 1'b0, 1'b0);
        send_sample(32'sd3);
        send_sample(-32'sd3);
        configure(msf_pkg::MODE_SMOOTH, 16'd1000, 17'd0, 25'h1000000, 1'b0, 1'b0);
        send_sample(32'sh40000000);
        send_sample(-32'sd5);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 58; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            random_config();
            // back up the output while samples keep coming
            if (phase == 4 || phase == 12)
                hold_pending = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((phase == 9 || phase == 15) && n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_sample(next_sample());
            end
        end

        stall_pct = 0;
        wait_for_results();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d samples, checked %0d results over %0d register settings",
                 samples_sent, results_seen, settings_used);
        $display("All four modes, saturation and angle wrap under gaps, stalls and backpressure");
        if (mismatches == 0 && outstanding == 0)
            $display("[multimode_smoothing_filter] OK");
        else
            $display("[multimode_smoothing_filter] ERROR");
        $finish;
    end

endmodule : tb_top
`default_nettype wire
